@@ hdl/dfpq_pkg.sv @@
package dfpq_pkg;

  typedef enum logic {
    OpQuantize = 1'b0,
    OpLoad     = 1'b1
  } op_e;

  // Code ranges, full and half, for the two rounding modes, stochastic and nearest.
  localparam int FullStoch = 32768;
  localparam int HalfStoch = 16384;
  localparam int FullNear  = 128;
  localparam int HalfNear  = 64;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] sample;
    logic               stochastic;
    logic [11:0]        random_fraction;
    logic               last;
    logic [4:0]         new_step;
  } dfpq_in_t;

  typedef struct packed {
    logic signed [15:0] code;
    logic signed [31:0] dequant_value;
    logic               large_overflow;
    logic               small_overflow;
    logic [4:0]         step_after;
  } dfpq_out_t;

  // Quantizer result without the step, as it leaves the datapath.
  typedef struct packed {
    logic signed [15:0] code;
    logic signed [31:0] dequant_value;
    logic               large_overflow;
    logic               small_overflow;
  } dfpq_quant_t;

endpackage

@@ hdl/dynamic_fixed_point_quantizer_unit.sv @@
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   in_data_i   (dfpq_in_t)
// out      output     out_valid_o/out_stall_i out_data_o  (dfpq_out_t)
// cfg      input      cfg_we_i                cfg_wdata_i (freeze_step)
// One beat is accepted per cycle while in_stall_o is low.
// The beat is held in an input register, quantized, and captured in the result register.
// The step and the overflow history advance as a beat moves into the result register.
// An output stall holds a valid result; the input then stalls only when both are full.
// Reset clears the step, the overflow history, freeze_step and both valid flags.
module dynamic_fixed_point_quantizer_unit
  import dfpq_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int MAX_STEP  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dfpq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dfpq_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  localparam logic [4:0] MaxStep = 5'(MAX_STEP);

  logic        in_vld_q;
  dfpq_in_t    in_q;
  logic        out_vld_q;
  dfpq_out_t   out_q;
  logic [4:0]  step_q;
  logic [4:0]  step_d;
  logic        seen_large_q;
  logic        seen_large_d;
  logic        seen_small_q;
  logic        seen_small_d;
  logic        freeze_q;
  logic        advance;
  logic        in_take;
  dfpq_quant_t quant;
  dfpq_out_t   out_d;
  logic        any_large;
  logic        any_small;

  dfpq_datapath #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_STEP (MAX_STEP)
  ) u_datapath (
    .sample_i         (in_q.sample),
    .stochastic_i     (in_q.stochastic),
    .random_fraction_i(in_q.random_fraction),
    .step_i           (step_q),
    .result_o         (quant)
  );

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_take    = !in_vld_q || advance;
  assign in_stall_o = !in_take;

  always_comb begin
    any_large    = seen_large_q || quant.large_overflow;
    any_small    = seen_small_q || quant.small_overflow;
    step_d       = step_q;
    seen_large_d = any_large;
    seen_small_d = any_small;
    out_d        = '0;
    if (in_q.operation == OpLoad) begin
      step_d       = (in_q.new_step > MaxStep) ? MaxStep : in_q.new_step;
      seen_large_d = 1'b0;
      seen_small_d = 1'b0;
    end else begin
      out_d.code           = quant.code;
      out_d.dequant_value  = quant.dequant_value;
      out_d.large_overflow = quant.large_overflow;
      out_d.small_overflow = quant.small_overflow;
      if (in_q.last) begin
        seen_large_d = 1'b0;
        seen_small_d = 1'b0;
        if (!freeze_q) begin
          if (any_large) begin
            if (step_q != 5'd0) begin
              step_d = step_q - 5'd1;
            end
          end else if (!any_small) begin
            if (step_q < MaxStep) begin
              step_d = step_q + 5'd1;
            end
          end
        end
      end
    end
    out_d.step_after = step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      step_q       <= '0;
      seen_large_q <= 1'b0;
      seen_small_q <= 1'b0;
      freeze_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        freeze_q <= cfg_wdata_i;
      end
      if (in_take) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q    <= 1'b1;
        step_q       <= step_d;
        seen_large_q <= seen_large_d;
        seen_small_q <= seen_small_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/dfpq_datapath.sv @@
module dfpq_datapath
  import dfpq_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int MAX_STEP  = 16
) (
  input  logic signed [31:0] sample_i,
  input  logic               stochastic_i,
  input  logic [11:0]        random_fraction_i,
  input  logic [4:0]         step_i,
  output dfpq_quant_t        result_o
);

  localparam int TW    = 32 + MAX_STEP;
  localparam int QBase = TW - FRAC_BITS;
  localparam int QW    = (QBase + 1 > 18) ? QBase + 1 : 18;
  localparam int SW    = FRAC_BITS + 13;
  localparam int DW    = (16 + FRAC_BITS > 33) ? 16 + FRAC_BITS : 33;

  logic signed [TW-1:0] scaled;
  logic [FRAC_BITS-1:0] frac;
  logic [SW-1:0]        stoch_sum;
  logic                 round_up;
  logic signed [QW-1:0] q_floor;
  logic signed [QW-1:0] q_round;
  logic signed [QW-1:0] full;
  logic signed [QW-1:0] half;
  logic signed [15:0]   code;
  logic signed [DW-1:0] code_ext;
  logic signed [DW-1:0] dq_wide;
  logic signed [31:0]   dq;

  always_comb begin
    scaled    = $signed({{MAX_STEP{sample_i[31]}}, sample_i}) <<< step_i;
    frac      = scaled[FRAC_BITS-1:0];
    q_floor   = $signed({{(QW - QBase){scaled[TW-1]}}, scaled[TW-1:FRAC_BITS]});
    stoch_sum = {1'b0, frac, 12'b0} + (SW'(random_fraction_i) << FRAC_BITS);
    round_up  = stochastic_i ? stoch_sum[SW-1] : frac[FRAC_BITS-1];
    q_round   = q_floor + QW'(round_up);

    full = stochastic_i ? QW'(FullStoch) : QW'(FullNear);
    half = stochastic_i ? QW'(HalfStoch) : QW'(HalfNear);

    if (q_round > full - QW'(1)) begin
      code = 16'((full - QW'(1)));
    end else if (q_round < -full) begin
      code = 16'(-full);
    end else begin
      code = q_round[15:0];
    end

    code_ext = $signed({{(DW - 16){code[15]}}, code}) <<< FRAC_BITS;
    dq_wide  = code_ext >>> step_i;
    if (dq_wide > DW'(32'sh7fff_ffff)) begin
      dq = 32'sh7fff_ffff;
    end else if (dq_wide < $signed({{(DW - 32){1'b1}}, 32'h8000_0000})) begin
      dq = 32'sh8000_0000;
    end else begin
      dq = dq_wide[31:0];
    end

    result_o.code           = code;
    result_o.dequant_value  = dq;
    result_o.large_overflow = (q_round >= full) || (q_round < -full);
    result_o.small_overflow = (q_round >= half) || (q_round < -half);
  end

endmodule
